@@ rtl/vector_reflection_unit_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the vector reflection unit
// Shared property wrappers used by the core's checks.
// ----------------------------------------------------------------------------
`ifndef VECTOR_REFLECTION_UNIT_CORE_DEFINES_SVH
`define VECTOR_REFLECTION_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define VRU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vru same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define VRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vru next-cycle check failed");

`endif

@@ rtl/vru_pkg.sv @@
// ----------------------------------------------------------------------------
// Vector reflection unit package
// Stage counts, widths and the data carried by the square root and divider
// cells.
// ----------------------------------------------------------------------------
package vru_pkg;

	// Fraction bits of a unit component (Q1.30).
	localparam int UNIT_FRAC   = 30;
	// One result bit per square root cell, one quotient bit per divider cell.
	localparam int SQRT_STEPS  = 32;
	localparam int DIV_STEPS   = 31;
	// Total pipeline depth, input register to output register.
	localparam int N_STAGES    = 5 + SQRT_STEPS + 1 + DIV_STEPS + 7;

	// Data handed from one square root cell to the next.
	typedef struct packed {
		logic [63:0] rad;
		logic [35:0] rem;
		logic [31:0] root;
	} sqrt_step_t;

	// Data handed from one divider cell to the next.
	typedef struct packed {
		logic [31:0] rem;
		logic [30:0] num;
		logic [30:0] quo;
		logic [31:0] den;
	} div_step_t;

	// Sideband that travels alongside the square root chain.
	typedef struct packed {
		logic [1:0][2:0][31:0] smag;
		logic [1:0][2:0]       neg;
		logic [1:0]            zero;
	} sq_side_t;

	// Sideband that travels alongside the divider chain.
	typedef struct packed {
		logic [1:0][2:0] neg;
		logic [1:0]      zero;
	} dv_side_t;

endpackage

@@ rtl/vru_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// Square root cell
// Produces one bit of an integer square root per cycle while en is high and hands the partial
// result to the next cell.
// ----------------------------------------------------------------------------
module vru_sqrt_cell import vru_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  sqrt_step_t d,
	output sqrt_step_t q
);

	logic [35:0] rsh;
	logic [35:0] trial;
	logic        ge;

	// Bring down the next two radicand bits and try the next root bit.
	always_comb begin
		rsh   = {d.rem[33:0], d.rad[63:62]};
		trial = {2'b00, d.root, 2'b01};
		ge    = (rsh >= trial);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q.rad  <= {d.rad[61:0], 2'b00};
			q.rem  <= ge ? (rsh - trial) : rsh;
			q.root <= {d.root[30:0], ge};
		end
	end

endmodule

@@ rtl/vru_div_cell.sv @@
// ----------------------------------------------------------------------------
// Divider cell
// Produces one quotient bit of a restoring division per cycle while en is high and hands the
// partial remainder to the next cell.
// ----------------------------------------------------------------------------
module vru_div_cell import vru_pkg::*; (
	input  logic      clk,
	input  logic      en,
	input  div_step_t d,
	output div_step_t q
);

	logic [32:0] rsh;
	logic [32:0] diff;
	logic        ge;

	// Shift in the next dividend bit and subtract the divisor if it fits.
	always_comb begin
		rsh  = {d.rem, d.num[30]};
		diff = rsh - {1'b0, d.den};
		ge   = (rsh >= {1'b0, d.den});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q.rem <= ge ? diff[31:0] : rsh[31:0];
			q.num <= {d.num[29:0], 1'b0};
			q.quo <= {d.quo[29:0], ge};
			q.den <= d.den;
		end
	end

endmodule

@@ rtl/vector_reflection_unit_core.sv @@
// ----------------------------------------------------------------------------
// Vector reflection unit core
// Throughput: one request per cycle unless the output stalls; the 32-cell square root chain and the
// 31-cell divider chain each finish one bit per cell per cycle while the pipeline advances.
// Reset: arst_n clears only the stage valid bits; payload is not reset.
// Normalizes incident and normal vectors and returns r = d - 2n(n.d), Q1.30.
// ----------------------------------------------------------------------------
`include "vector_reflection_unit_core_defines.svh"

module vector_reflection_unit_core import vru_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] incident_x,
	input  logic [31:0] incident_y,
	input  logic [31:0] incident_z,
	input  logic [31:0] normal_x,
	input  logic [31:0] normal_y,
	input  logic [31:0] normal_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] reflected_x,
	output logic [31:0] reflected_y,
	output logic [31:0] reflected_z,
	output logic        degenerate
);

	logic                en;
	logic                accept;
	logic [N_STAGES:1]   vld_q;

	// Pipeline control: all stages advance together; the input stage may
	// also fill while the rest is held.
	assign en       = out_ready || !vld_q[N_STAGES];
	assign in_ready = en || !vld_q[1];
	assign accept   = in_valid && in_ready;
	assign out_valid = vld_q[N_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (accept) begin
				vld_q[1] <= 1'b1;
			end else if (en) begin
				vld_q[1] <= 1'b0;
			end
			if (en) begin
				vld_q[N_STAGES:2] <= vld_q[N_STAGES-1:1];
			end
		end
	end

	// Stage 1: capture the request.
	logic [1:0][2:0][31:0] vin_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			vin_s1[0][0] <= incident_x;
			vin_s1[0][1] <= incident_y;
			vin_s1[0][2] <= incident_z;
			vin_s1[1][0] <= normal_x;
			vin_s1[1][1] <= normal_y;
			vin_s1[1][2] <= normal_z;
		end
	end

	// Stage 2: magnitudes, signs, largest magnitude and prescale shift.
	logic [1:0][2:0][31:0] mag_c;
	logic [1:0][31:0]      max_c;
	logic [1:0][4:0]       k_c;
	logic [1:0][2:0][31:0] mag_s2;
	logic [1:0][2:0]       neg_s2;
	logic [1:0][4:0]       k_s2;
	logic [1:0]            zero_s2;

	always_comb begin
		for (int v = 0; v < 2; v++) begin
			for (int i = 0; i < 3; i++) begin
				mag_c[v][i] = vin_s1[v][i][31] ? (~vin_s1[v][i] + 32'd1) : vin_s1[v][i];
			end
			max_c[v] = mag_c[v][0];
			if (mag_c[v][1] > max_c[v]) begin
				max_c[v] = mag_c[v][1];
			end
			if (mag_c[v][2] > max_c[v]) begin
				max_c[v] = mag_c[v][2];
			end
			// The highest set bit decides the shift; none is needed from bit 30 up.
			k_c[v] = 5'd0;
			for (int b = 0; b < 32; b++) begin
				if (max_c[v][b]) begin
					k_c[v] = (b >= UNIT_FRAC) ? 5'd0 : 5'(UNIT_FRAC - b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int v = 0; v < 2; v++) begin
				for (int i = 0; i < 3; i++) begin
					mag_s2[v][i] <= mag_c[v][i];
					neg_s2[v][i] <= vin_s1[v][i][31];
				end
				k_s2[v]    <= k_c[v];
				zero_s2[v] <= (max_c[v] == 32'd0);
			end
		end
	end

	// Stage 3: prescale so the largest magnitude reaches 2^30.
	sq_side_t side_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int v = 0; v < 2; v++) begin
				for (int i = 0; i < 3; i++) begin
					side_s3.smag[v][i] <= mag_s2[v][i] << k_s2[v];
				end
			end
			side_s3.neg  <= neg_s2;
			side_s3.zero <= zero_s2;
		end
	end

	// Stage 4: squares of the scaled magnitudes.
	logic [1:0][2:0][63:0] sq_s4;
	sq_side_t              side_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int v = 0; v < 2; v++) begin
				for (int i = 0; i < 3; i++) begin
					sq_s4[v][i] <= side_s3.smag[v][i] * side_s3.smag[v][i];
				end
			end
			side_s4 <= side_s3;
		end
	end

	// Stage 5: sum of squares.
	logic [1:0][63:0] ssum_s5;
	sq_side_t         side_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int v = 0; v < 2; v++) begin
				ssum_s5[v] <= sq_s4[v][0] + sq_s4[v][1] + sq_s4[v][2];
			end
			side_s5 <= side_s4;
		end
	end

	// Square root chain, one lane per vector.
	sqrt_step_t sqc [0:SQRT_STEPS][0:1];
	sq_side_t   side_chain_q [0:SQRT_STEPS-1];

	always_comb begin
		for (int v = 0; v < 2; v++) begin
			sqc[0][v].rad  = ssum_s5[v];
			sqc[0][v].rem  = '0;
			sqc[0][v].root = '0;
		end
	end

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		for (genvar v = 0; v < 2; v++) begin : g_lane
			vru_sqrt_cell u_cell (
				.clk (clk),
				.en  (en),
				.d   (sqc[j][v]),
				.q   (sqc[j+1][v])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_chain_q[0] <= side_s5;
			for (int j = 1; j < SQRT_STEPS; j++) begin
				side_chain_q[j] <= side_chain_q[j-1];
			end
		end
	end

	// Divider setup: dividend is |v| * 2^30 plus half the length.
	div_step_t dv_s38 [0:1][0:2];
	dv_side_t  dvside_s38;
	logic [1:0][2:0][61:0] dvd_c;

	always_comb begin
		for (int v = 0; v < 2; v++) begin
			for (int i = 0; i < 3; i++) begin
				dvd_c[v][i] = {side_chain_q[SQRT_STEPS-1].smag[v][i], 30'd0}
				            + {31'd0, sqc[SQRT_STEPS][v].root[31:1]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int v = 0; v < 2; v++) begin
				for (int i = 0; i < 3; i++) begin
					dv_s38[v][i].rem <= {1'b0, dvd_c[v][i][61:31]};
					dv_s38[v][i].num <= dvd_c[v][i][30:0];
					dv_s38[v][i].quo <= '0;
					dv_s38[v][i].den <= sqc[SQRT_STEPS][v].root;
				end
			end
			dvside_s38.neg  <= side_chain_q[SQRT_STEPS-1].neg;
			dvside_s38.zero <= side_chain_q[SQRT_STEPS-1].zero;
		end
	end

	// Divider chain, one lane per component of each vector.
	div_step_t dvc [0:DIV_STEPS][0:1][0:2];
	dv_side_t  dvside_chain_q [0:DIV_STEPS-1];

	always_comb begin
		for (int v = 0; v < 2; v++) begin
			for (int i = 0; i < 3; i++) begin
				dvc[0][v][i] = dv_s38[v][i];
			end
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		for (genvar v = 0; v < 2; v++) begin : g_vec
			for (genvar i = 0; i < 3; i++) begin : g_comp
				vru_div_cell u_cell (
					.clk (clk),
					.en  (en),
					.d   (dvc[j][v][i]),
					.q   (dvc[j+1][v][i])
				);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvside_chain_q[0] <= dvside_s38;
			for (int j = 1; j < DIV_STEPS; j++) begin
				dvside_chain_q[j] <= dvside_chain_q[j-1];
			end
		end
	end

	// Unit components with their signs restored.
	logic signed [31:0] ud_s70 [0:2];
	logic signed [31:0] un_s70 [0:2];
	logic               deg_s70;
	dv_side_t           dvs_end;

	assign dvs_end = dvside_chain_q[DIV_STEPS-1];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ud_s70[i] <= dvs_end.neg[0][i] ? -$signed({1'b0, dvc[DIV_STEPS][0][i].quo})
				                               :  $signed({1'b0, dvc[DIV_STEPS][0][i].quo});
				un_s70[i] <= dvs_end.neg[1][i] ? -$signed({1'b0, dvc[DIV_STEPS][1][i].quo})
				                               :  $signed({1'b0, dvc[DIV_STEPS][1][i].quo});
			end
			deg_s70 <= dvs_end.zero[0] || dvs_end.zero[1];
		end
	end

	// Dot product terms.
	logic signed [63:0] prod_s71 [0:2];
	logic signed [31:0] ud_s71 [0:2];
	logic signed [31:0] un_s71 [0:2];
	logic               deg_s71;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s71[i] <= un_s70[i] * ud_s70[i];
			end
			ud_s71  <= ud_s70;
			un_s71  <= un_s70;
			deg_s71 <= deg_s70;
		end
	end

	// Dot product sum.
	logic signed [63:0] dot_s72;
	logic signed [31:0] ud_s72 [0:2];
	logic signed [31:0] un_s72 [0:2];
	logic               deg_s72;

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s72 <= prod_s71[0] + prod_s71[1] + prod_s71[2];
			ud_s72  <= ud_s71;
			un_s72  <= un_s71;
			deg_s72 <= deg_s71;
		end
	end

	// Round the dot product to Q1.30, half away from zero.
	logic [63:0]        dmag_c;
	logic [63:0]        dsum_c;
	logic signed [33:0] qd_s73;
	logic signed [31:0] ud_s73 [0:2];
	logic signed [31:0] un_s73 [0:2];
	logic               deg_s73;

	always_comb begin
		dmag_c = dot_s72[63] ? (~dot_s72 + 64'd1) : dot_s72;
		dsum_c = dmag_c + (64'd1 << (UNIT_FRAC - 1));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qd_s73  <= dot_s72[63] ? -$signed({1'b0, dsum_c[UNIT_FRAC+32:UNIT_FRAC]})
			                       :  $signed({1'b0, dsum_c[UNIT_FRAC+32:UNIT_FRAC]});
			ud_s73  <= ud_s72;
			un_s73  <= un_s72;
			deg_s73 <= deg_s72;
		end
	end

	// Scaled normal components n_i * q.
	logic signed [65:0] tw_c [0:2];
	logic signed [63:0] t_s74 [0:2];
	logic signed [31:0] ud_s74 [0:2];
	logic               deg_s74;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tw_c[i] = un_s73[i] * qd_s73;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				t_s74[i] <= tw_c[i][63:0];
			end
			ud_s74  <= ud_s73;
			deg_s74 <= deg_s73;
		end
	end

	// Round 2 n_i q back to Q1.30.
	logic [63:0]        tmag_c [0:2];
	logic [63:0]        tsum_c [0:2];
	logic signed [35:0] rnd_s75 [0:2];
	logic signed [31:0] ud_s75 [0:2];
	logic               deg_s75;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tmag_c[i] = t_s74[i][63] ? (~t_s74[i] + 64'd1) : t_s74[i];
			tsum_c[i] = tmag_c[i] + (64'd1 << (UNIT_FRAC - 2));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rnd_s75[i] <= t_s74[i][63]
				            ? -$signed({1'b0, tsum_c[i][UNIT_FRAC+33:UNIT_FRAC-1]})
				            :  $signed({1'b0, tsum_c[i][UNIT_FRAC+33:UNIT_FRAC-1]});
			end
			ud_s75  <= ud_s74;
			deg_s75 <= deg_s74;
		end
	end

	// Subtract, saturate and force zeros for a degenerate request.
	logic signed [36:0] r_c [0:2];
	logic [31:0]        res_c [0:2];
	logic [31:0]        res_s76 [0:2];
	logic               deg_s76;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			r_c[i] = 37'(ud_s75[i]) - 37'(rnd_s75[i]);
			if (r_c[i] > 37'sh0_7FFF_FFFF) begin
				res_c[i] = 32'h7FFF_FFFF;
			end else if (r_c[i] < -37'sh0_8000_0000) begin
				res_c[i] = 32'h8000_0000;
			end else begin
				res_c[i] = r_c[i][31:0];
			end
			if (deg_s75) begin
				res_c[i] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s76 <= res_c;
			deg_s76 <= deg_s75;
		end
	end

	assign reflected_x = res_s76[0];
	assign reflected_y = res_s76[1];
	assign reflected_z = res_s76[2];
	assign degenerate  = deg_s76;

	// A degenerate result carries all-zero components.
	`VRU_ASSERT_NOW(a_deg_zero, clk, arst_n, out_valid && degenerate, ~|{reflected_x, reflected_y, reflected_z})
	// The pipeline never blocks input while the output side drains.
	`VRU_ASSERT_NOW(a_ready_drain, clk, arst_n, out_ready, in_ready)
	// An empty output register never stalls the pipeline.
	`VRU_ASSERT_NOW(a_ready_empty, clk, arst_n, !out_valid, in_ready)
	// A held result stays valid until it is taken.
	`VRU_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(reflected_x) && $stable(degenerate))

endmodule

@@ test/vector_reflection_unit_core_tb.sv @@
// ----------------------------------------------------------------------------
// Vector reflection unit core testbench
// Drives incident and normal vectors through the valid/ready request channel,
// predicts each reflected unit direction in exact fixed point and compares it
// field by field with the block's result, under several idling patterns.
// ----------------------------------------------------------------------------
module vector_reflection_unit_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] ix, iy, iz, nx, ny, nz;
	} vec_req_t;

	typedef struct {
		logic [31:0] rx, ry, rz;
		logic        degen;
	} reflect_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] incident_x = '0, incident_y = '0, incident_z = '0;
	logic [31:0] normal_x = '0, normal_y = '0, normal_z = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] reflected_x, reflected_y, reflected_z;
	logic        degenerate;

	vec_req_t pending_reqs[$];
	reflect_t expected_reflections[$];
	int       mismatch_count = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	int       hold_off_cycles = 0;
	bit       stim_done = 1'b0;
	bit       req_taken = 1'b0;

	vector_reflection_unit_core u_dut (.*);

	always #5 clk = ~clk;

	// Magnitude of a signed 64-bit value.
	function automatic logic [63:0] abs64(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Integer square root, floor.
	function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s = s - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Rounded shift of a magnitude, sign restored.
	function automatic longint round_shr(input longint v, input int sh);
		logic [63:0] m;
		m = (abs64(v) + (64'd1 << (sh - 1))) >> sh;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	// Normalizes a vector to Q1.30; returns 0 for the zero vector.
	function automatic bit to_unit(input longint v[3], output longint u[3]);
		logic [63:0] m, s, len, q;
		longint sv[3];
		longint scale;
		m = 0;
		s = 0;
		scale = 1;
		foreach (v[i]) if (abs64(v[i]) > m) m = abs64(v[i]);
		if (m == 0) return 0;
		while (m < (64'd1 << 30)) begin
			m = m << 1;
			scale = scale * 2;
		end
		foreach (v[i]) begin
			sv[i] = v[i] * scale;
			s = s + abs64(sv[i]) * abs64(sv[i]);
		end
		len = floor_sqrt(s);
		foreach (v[i]) begin
			q = ((abs64(sv[i]) << 30) + (len >> 1)) / len;
			u[i] = (sv[i] < 0) ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	// Reflected unit direction of one request.
	function automatic reflect_t reflect_vec(input vec_req_t r);
		reflect_t res;
		longint d[3], n[3], ud[3], un[3], p, q, t, o;
		logic [31:0] outs[3];
		d[0] = signed'(r.ix); d[1] = signed'(r.iy); d[2] = signed'(r.iz);
		n[0] = signed'(r.nx); n[1] = signed'(r.ny); n[2] = signed'(r.nz);
		res = '{rx: '0, ry: '0, rz: '0, degen: 1'b1};
		if (!to_unit(d, ud) || !to_unit(n, un)) return res;
		p = 0;
		for (int i = 0; i < 3; i++) p = p + un[i] * ud[i];
		q = round_shr(p, 30);
		for (int i = 0; i < 3; i++) begin
			t = un[i] * q;
			o = ud[i] - round_shr(t, 29);
			if (o > 64'sd2147483647) o = 64'sd2147483647;
			if (o < -64'sd2147483648) o = -64'sd2147483648;
			outs[i] = o[31:0];
		end
		res = '{rx: outs[0], ry: outs[1], rz: outs[2], degen: 1'b0};
		return res;
	endfunction

	function automatic logic [31:0] rand_comp(input int kind);
		case (kind)
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'($urandom_range(0, 8)) - 32'd4;
			3: return $urandom >> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	function automatic vec_req_t make_req(input logic [31:0] a, b, c, e, f, g);
		vec_req_t r;
		r = '{ix: a, iy: b, iz: c, nx: e, ny: f, nz: g};
		return r;
	endfunction

	// Remember whether the offered request was taken at this rising edge.
	always @(posedge clk) begin
		req_taken <= arst_n && in_valid && in_ready;
	end

	// Request driver: inputs change on the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || req_taken) begin
				// Previous request was accepted at the last rising edge.
				if (req_taken) void'(pending_reqs.pop_front());
				if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
				begin
					in_valid <= 1'b1;
					incident_x <= pending_reqs[0].ix;
					incident_y <= pending_reqs[0].iy;
					incident_z <= pending_reqs[0].iz;
					normal_x <= pending_reqs[0].nx;
					normal_y <= pending_reqs[0].ny;
					normal_z <= pending_reqs[0].nz;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver ready, with an optional long hold-off.
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Prediction on accepted requests and checking of accepted results.
	always @(posedge clk) begin
		reflect_t want;
		if (arst_n && in_valid && in_ready) begin
			expected_reflections.push_back(reflect_vec(make_req(incident_x,
				incident_y, incident_z, normal_x, normal_y, normal_z)));
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_reflections.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) $display("unexpected result at %0t", $realtime);
			end else begin
				want = expected_reflections.pop_front();
				if (reflected_x !== want.rx || reflected_y !== want.ry ||
					reflected_z !== want.rz || degenerate !== want.degen) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: exp %h %h %h %b got %h %h %h %b",
							want.rx, want.ry, want.rz, want.degen,
							reflected_x, reflected_y, reflected_z, degenerate);
				end
			end
		end
	end

	// Stimulus and phases.
	initial begin
		logic [31:0] z;
		int k;
		z = '0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed: zero vectors, extremes, axes, head-on and grazing.
		pending_reqs.push_back(make_req(z, z, z, 32'h10000, z, z));
		pending_reqs.push_back(make_req(32'h10000, z, z, z, z, z));
		pending_reqs.push_back(make_req(z, z, z, z, z, z));
		pending_reqs.push_back(make_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
		pending_reqs.push_back(make_req(32'h7fff_ffff, z, z, 32'h8000_0000, z, z));
		pending_reqs.push_back(make_req(32'h1, z, z, z, 32'h1, z));
		pending_reqs.push_back(make_req(32'hffff_ffff, 32'hffff_ffff, 32'h1,
			z, z, 32'hffff_ffff));
		pending_reqs.push_back(make_req(32'h10000, 32'hffff_0000, z, z, 32'h10000, z));
		pending_reqs.push_back(make_req(z, z, 32'h8000_0000, z, z, 32'h8000_0000));
		pending_reqs.push_back(make_req(32'h1, 32'h7fff_ffff, 32'h8000_0000,
			32'h3, 32'h5, 32'hffff_fff9));
		pending_reqs.push_back(make_req(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
		pending_reqs.push_back(make_req(32'h5555_5555, 32'haaaa_aaaa, z,
			32'haaaa_aaaa, 32'h5555_5555, 32'h1));
		pending_reqs.push_back(make_req(32'h4000_0001, 32'h1, z,
			32'hbfff_ffff, 32'h3, 32'h1));

		// Random requests over four idling phases, long hold-off in the second.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 0; recv_stall_pct = 50; hold_off_cycles = 300; end
				2: begin send_idle_pct = 50; recv_stall_pct = 0; end
				default: begin send_idle_pct = 32; recv_stall_pct = 32; end
			endcase
			for (int i = 0; i < 110; i++) begin
				k = $urandom_range(0, 9);
				pending_reqs.push_back(make_req(rand_comp(k), rand_comp($urandom_range(2, 9)),
					rand_comp($urandom_range(0, 9)), rand_comp($urandom_range(0, 9)),
					rand_comp($urandom_range(2, 9)), rand_comp(k)));
			end
			wait (pending_reqs.size() == 0 && !in_valid);
			wait (expected_reflections.size() == 0);
		end
		stim_done = 1'b1;
		repeat (100) @(posedge clk);
		if (mismatch_count == 0 && expected_reflections.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Overall time limit.
	initial begin
		#2ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

@@ vector_reflection_unit_core.f @@
+incdir+rtl
rtl/vru_pkg.sv
rtl/vru_sqrt_cell.sv
rtl/vru_div_cell.sv
rtl/vector_reflection_unit_core.sv
test/vector_reflection_unit_core_tb.sv
